FILE: rtl/stil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stil_pkg
// Types and codes shared by the sorted table blocks: operation and status
// codes, the stored entry layout, the result record and the control states.
// ----------------------------------------------------------------------------
package stil_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] price;
    logic signed [31:0] count;
  } entry_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    entry_t  entry;
    logic    last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

FILE: rtl/stil_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stil_if
// Valid/ready channels of the sorted table: request items in, result items
// out.
// ----------------------------------------------------------------------------
interface stil_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  op;
  logic signed [31:0] entry_key;
  logic        [31:0] price_word;
  logic signed [31:0] item_count;

  modport source (output valid, op, entry_key, price_word, item_count, input ready);
  modport sink (input valid, op, entry_key, price_word, item_count, output ready);
endinterface

interface stil_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] out_key;
  logic        [31:0] out_price;
  logic signed [31:0] out_count;
  logic               last;

  modport source (output valid, status, out_key, out_price, out_count, last, input ready);
  modport sink (input valid, status, out_key, out_price, out_count, last, output ready);
endinterface

FILE: rtl/sorted_table_insert_lookup_top.sv
`timescale 1ns / 1ps
// Insert: shifts the entries above the insert place up, then writes the item;
//   a full table goes straight to the result; lookup and dump scan every filled entry.
// Throughput: one item at a time; the single read port of the entry memory
//   walks the table one entry per cycle unless a found entry waits for a busy result register.
// Reset: clears fill and control state; memory contents are kept and
//   need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_table_insert_lookup_top
// Sorted table of keyed entries with insert, lookup and dump operations.
// ----------------------------------------------------------------------------
module sorted_table_insert_lookup_top #(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst,
  stil_in_if.sink    req,
  stil_out_if.source rsp
);
  import stil_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  logic          out_free;
  result_t       res;

  stil_store #(.CAPACITY(CAPACITY)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  stil_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .res       (res)
  );

  stil_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .res  (res),
    .free (out_free),
    .rsp  (rsp)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!rsp.valid || rsp.ready))
    else $error("result loaded over an untaken item");

  a_no_accept_on_write: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !mem_we)
    else $error("item accepted during a table write");

  a_busy_after_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !req.ready)
    else $error("ready raised directly after a table write");

endmodule

FILE: rtl/stil_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stil_store
// Entry memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module stil_store #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  stil_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output stil_pkg::entry_t rdata
);
  import stil_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stil_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stil_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module stil_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  stil_pkg::result_t res,
  output logic              free,
  stil_out_if.source        rsp
);
  import stil_pkg::*;

  assign free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res.valid) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      rsp.status    <= res.status;
      rsp.out_key   <= res.entry.key;
      rsp.out_price <= res.entry.price;
      rsp.out_count <= res.entry.count;
      rsp.last      <= res.last;
    end
  end

endmodule

FILE: rtl/stil_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stil_ctrl
// Sequencer: shifts entries up from the top while searching the insert
// place, scans the table for lookup and dump, and issues result items.
// ----------------------------------------------------------------------------
module stil_ctrl #(
  parameter int CAPACITY = 32,
  localparam int AW = $clog2(CAPACITY),
  localparam int FW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  stil_in_if.sink           req,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output stil_pkg::entry_t  mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  stil_pkg::entry_t  mem_rdata,
  input  logic              out_free,
  output stil_pkg::result_t res
);
  import stil_pkg::*;

  state_t  state, state_next;
  op_t     op_r, op_r_next;
  entry_t  item, item_next;
  entry_t  pend, pend_next;
  logic    pend_valid, pend_valid_next;
  status_t fin_status, fin_status_next;
  logic [FW-1:0] fill, fill_next;
  logic [AW-1:0] idx, idx_next;

  logic          match;
  logic          at_end;
  logic          stall;
  logic [AW-1:0] top_addr;
  op_t           req_op;

  assign req_op   = op_t'(req.op);
  assign top_addr = AW'(fill - FW'(1));
  assign match    = (op_r == OP_DUMP) || (mem_rdata.key == item.key);
  assign at_end   = (FW'(idx) == (fill - FW'(1)));
  assign stall    = match && pend_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    item       <= item_next;
    pend       <= pend_next;
    fin_status <= fin_status_next;
    idx        <= idx_next;
  end

  always_comb begin
    state_next      = state;
    op_r_next       = op_r;
    item_next       = item;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    fin_status_next = fin_status;
    fill_next       = fill;
    idx_next        = idx;
    req.ready       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = item;
    mem_raddr       = '0;
    res             = '0;

    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          op_r_next       = req_op;
          item_next       = '{key: req.entry_key, price: req.price_word,
                              count: req.item_count};
          pend_valid_next = 1'b0;
          unique case (req_op)
            OP_INSERT: begin
              if (fill == FW'(CAPACITY)) begin
                fin_status_next = ST_FULL;
                state_next      = S_FINISH;
              end else begin
                fin_status_next = ST_INSERTED;
                if (fill == '0) begin
                  state_next = S_PLACE;
                end else begin
                  mem_raddr  = top_addr;
                  idx_next   = top_addr;
                  state_next = S_SHIFT;
                end
              end
            end
            OP_LOOKUP, OP_DUMP: begin
              if (fill == '0) begin
                fin_status_next = (req_op == OP_DUMP) ? ST_EMPTY : ST_NOT_FOUND;
                state_next      = S_FINISH;
              end else begin
                fin_status_next = ST_NOT_FOUND;
                mem_raddr       = '0;
                idx_next        = '0;
                state_next      = S_SCAN;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx + 1'b1);
        if ($signed(item.key) < $signed(mem_rdata.key)) begin
          mem_wdata = mem_rdata;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            mem_raddr = AW'(idx - 1'b1);
            idx_next  = AW'(idx - 1'b1);
          end
        end else begin
          mem_wdata  = item;
          fill_next  = FW'(fill + 1'b1);
          state_next = S_FINISH;
        end
      end

      S_PLACE: begin
        mem_we     = 1'b1;
        mem_waddr  = '0;
        mem_wdata  = item;
        fill_next  = FW'(fill + 1'b1);
        state_next = S_FINISH;
      end

      S_SCAN: begin
        if (stall) begin
          mem_raddr = idx;
        end else begin
          mem_raddr = AW'(idx + 1'b1);
          idx_next  = AW'(idx + 1'b1);
          if (match) begin
            if (pend_valid) begin
              res.valid  = 1'b1;
              res.status = ST_FOUND;
              res.entry  = pend;
              res.last   = 1'b0;
            end
            pend_next       = mem_rdata;
            pend_valid_next = 1'b1;
          end
          if (at_end) begin
            state_next = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          res.valid = 1'b1;
          res.last  = 1'b1;
          if (pend_valid) begin
            res.status = ST_FOUND;
            res.entry  = pend;
          end else begin
            res.status = fin_status;
            unique case (fin_status)
              ST_INSERTED, ST_FULL: res.entry = item;
              ST_NOT_FOUND:         res.entry = '{key: item.key, price: '0, count: '0};
              default:              res.entry = '0;
            endcase
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
